// File: src/apsd_pkg.sv
package apsd_pkg;

	localparam int MaxNodes = 64;
	localparam int NodeW    = 6;
	localparam int CountW   = 7;
	localparam int AddrW    = 2 * NodeW;
	localparam int WeightW  = 16;
	localparam int DistW    = 17;
	localparam int SweepW   = AddrW + 1;
	localparam logic [DistW-1:0] DistLimit = 17'd100000;
	localparam logic [CountW-1:0] MaxCount = 7'd64;

	typedef enum logic [1:0] {
		OP_CLEAR   = 2'd0,
		OP_ADD     = 2'd1,
		OP_COMPUTE = 2'd2,
		OP_READ    = 2'd3
	} opcode_t;

	typedef enum logic [3:0] {
		ST_CLR,
		ST_IDLE,
		ST_ADD,
		ST_ADD2,
		ST_RD,
		ST_SRC,
		ST_SCAN,
		ST_RELAX
	} state_t;

endpackage

// File: src/apsd_ram.sv
module apsd_ram #(
	parameter int AW = 12,
	parameter int DW = 16
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);

	logic [DW-1:0] mem [2**AW];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: src/all_pairs_shortest_distance_unit.sv
// Channel   Direction  Handshake            Payload
// input     in         in_valid / in_stall   opcode, node_a, node_b, edge_weight
// output    out        out_valid / out_stall status, distance, reachable
// config    in         cfg_we                cfg_wdata (node_count)
//
// A rejected item or a zero-weight add is answered straight from idle; a read and an add
// wait on the registered store read, and an add that stores its weight writes both entries.
// Clear sweeps all 4096 store entries, one per cycle, before its transfer is answered.
// Compute sweeps the distance store, then per source zeroes its own entry and runs scan
// and relax passes over that source's row through one compare-add unit, until no
// reachable unfinished node is left.
// After reset the clear sweep over all 4096 entries runs with input stalled.
// The next item is taken while a result waits, as long as it is being drained.
module all_pairs_shortest_distance_unit (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [apsd_pkg::CountW-1:0]  cfg_wdata,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [1:0]                   opcode,
	input  logic [apsd_pkg::NodeW-1:0]   node_a,
	input  logic [apsd_pkg::NodeW-1:0]   node_b,
	input  logic [apsd_pkg::WeightW-1:0] edge_weight,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic                         status,
	output logic [apsd_pkg::DistW-1:0]   distance,
	output logic                         reachable
);
	import apsd_pkg::*;

	state_t              state_q, state_d;
	logic [CountW-1:0]   node_count_q;
	logic [CountW-1:0]   n_eff;
	logic [SweepW-1:0]   cnt_q, cnt_d;
	logic [CountW-1:0]   src_q, src_d;
	logic [CountW-1:0]   u_q, u_d;
	logic [DistW-1:0]    best_q, best_d;
	logic [MaxNodes-1:0] done_q, done_d;
	logic                clr_edge_q, clr_edge_d, cmp_q, cmp_d, resp_q, resp_d;
	logic [NodeW-1:0]    a_q, a_d, b_q, b_d;
	logic [WeightW-1:0]  w_q, w_d;
	logic                out_valid_q, out_valid_d, status_q, status_d, reach_q, reach_d;
	logic [DistW-1:0]    dist_q, dist_d;

	logic                e_we, d_we;
	logic [AddrW-1:0]    e_waddr, e_raddr, d_waddr, d_raddr;
	logic [WeightW-1:0]  e_wdata, e_rdata;
	logic [DistW-1:0]    d_wdata, d_rdata;

	logic                in_fire;
	logic [CountW-1:0]   v_c;
	logic [DistW:0]      cand_c;
	logic [DistW-1:0]    nb_c;
	logic [CountW-1:0]   nu_c;

	apsd_ram #(.AW(AddrW), .DW(WeightW)) u_edge (
		.clk(clk), .we(e_we), .waddr(e_waddr), .wdata(e_wdata),
		.raddr(e_raddr), .rdata(e_rdata)
	);

	apsd_ram #(.AW(AddrW), .DW(DistW)) u_dist (
		.clk(clk), .we(d_we), .waddr(d_waddr), .wdata(d_wdata),
		.raddr(d_raddr), .rdata(d_rdata)
	);

	assign n_eff    = (node_count_q > MaxCount) ? MaxCount : node_count_q;
	assign in_stall = (state_q != ST_IDLE) || (out_valid_q && out_stall);
	assign in_fire  = in_valid && !in_stall;
	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign distance  = dist_q;
	assign reachable = reach_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_CLR;
			node_count_q <= CountW'(1);
			cnt_q        <= '0;
			src_q        <= '0;
			clr_edge_q   <= 1'b1;
			cmp_q        <= 1'b0;
			resp_q       <= 1'b0;
			out_valid_q  <= 1'b0;
			done_q       <= '0;
		end else begin
			state_q     <= state_d;
			if (cfg_we) begin
				node_count_q <= cfg_wdata;
			end
			cnt_q       <= cnt_d;
			src_q       <= src_d;
			clr_edge_q  <= clr_edge_d;
			cmp_q       <= cmp_d;
			resp_q      <= resp_d;
			out_valid_q <= out_valid_d;
			done_q      <= done_d;
		end
	end

	always_ff @(posedge clk) begin
		u_q      <= u_d;
		best_q   <= best_d;
		a_q      <= a_d;
		b_q      <= b_d;
		w_q      <= w_d;
		status_q <= status_d;
		dist_q   <= dist_d;
		reach_q  <= reach_d;
	end

	always_comb begin
		state_d     = state_q;
		cnt_d       = cnt_q;
		src_d       = src_q;
		u_d         = u_q;
		best_d      = best_q;
		done_d      = done_q;
		clr_edge_d  = clr_edge_q;
		cmp_d       = cmp_q;
		resp_d      = resp_q;
		a_d         = a_q;
		b_d         = b_q;
		w_d         = w_q;
		out_valid_d = out_valid_q && out_stall;
		status_d    = status_q;
		dist_d      = dist_q;
		reach_d     = reach_q;
		e_we        = 1'b0;
		e_waddr     = '0;
		e_wdata     = '0;
		e_raddr     = '0;
		d_we        = 1'b0;
		d_waddr     = '0;
		d_wdata     = '0;
		d_raddr     = '0;
		v_c         = cnt_q[CountW-1:0] - CountW'(1);
		cand_c      = {1'b0, best_q} + {{(DistW+1-WeightW){1'b0}}, e_rdata};
		nb_c        = best_q;
		nu_c        = u_q;

		unique case (state_q)
			ST_CLR: begin
				e_we    = clr_edge_q;
				e_waddr = cnt_q[AddrW-1:0];
				d_we    = 1'b1;
				d_waddr = cnt_q[AddrW-1:0];
				d_wdata = DistLimit;
				cnt_d   = cnt_q + SweepW'(1);
				if (cnt_q[AddrW-1:0] == '1) begin
					cnt_d = '0;
					if (cmp_q) begin
						src_d   = '0;
						state_d = ST_SRC;
					end else begin
						state_d = ST_IDLE;
						if (resp_q) begin
							out_valid_d = 1'b1;
							status_d    = 1'b0;
							dist_d      = '0;
							reach_d     = 1'b0;
						end
					end
				end
			end
			ST_IDLE: begin
				if (in_fire) begin
					a_d = node_a;
					b_d = node_b;
					w_d = edge_weight;
					if (opcode == OP_CLEAR || opcode == OP_COMPUTE) begin
						clr_edge_d = (opcode == OP_CLEAR);
						cmp_d      = (opcode == OP_COMPUTE);
						resp_d     = 1'b1;
						cnt_d      = '0;
						state_d    = ST_CLR;
					end else if ({1'b0, node_a} >= n_eff || {1'b0, node_b} >= n_eff) begin
						out_valid_d = 1'b1;
						status_d    = 1'b1;
						dist_d      = '0;
						reach_d     = 1'b0;
					end else if (opcode == OP_ADD) begin
						if (edge_weight == '0) begin
							out_valid_d = 1'b1;
							status_d    = 1'b0;
							dist_d      = '0;
							reach_d     = 1'b0;
						end else begin
							e_raddr = {node_a, node_b};
							state_d = ST_ADD;
						end
					end else begin
						d_raddr = {node_a, node_b};
						state_d = ST_RD;
					end
				end
			end
			ST_ADD: begin
				if (e_rdata == '0 || w_q < e_rdata) begin
					e_we    = 1'b1;
					e_waddr = {a_q, b_q};
					e_wdata = w_q;
					state_d = ST_ADD2;
				end else begin
					out_valid_d = 1'b1;
					status_d    = 1'b0;
					dist_d      = '0;
					reach_d     = 1'b0;
					state_d     = ST_IDLE;
				end
			end
			ST_ADD2: begin
				e_we        = 1'b1;
				e_waddr     = {b_q, a_q};
				e_wdata     = w_q;
				out_valid_d = 1'b1;
				status_d    = 1'b0;
				dist_d      = '0;
				reach_d     = 1'b0;
				state_d     = ST_IDLE;
			end
			ST_RD: begin
				out_valid_d = 1'b1;
				status_d    = 1'b0;
				dist_d      = d_rdata;
				reach_d     = (d_rdata < DistLimit);
				state_d     = ST_IDLE;
			end
			ST_SRC: begin
				if (src_q >= n_eff) begin
					out_valid_d = 1'b1;
					status_d    = 1'b0;
					dist_d      = '0;
					reach_d     = 1'b0;
					state_d     = ST_IDLE;
				end else begin
					d_we    = 1'b1;
					d_waddr = {src_q[NodeW-1:0], src_q[NodeW-1:0]};
					d_wdata = '0;
					done_d  = '0;
					cnt_d   = '0;
					best_d  = DistLimit;
					u_d     = n_eff;
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				d_raddr = {src_q[NodeW-1:0], cnt_q[NodeW-1:0]};
				if (cnt_q != '0) begin
					if (!done_q[v_c[NodeW-1:0]] && d_rdata < best_q) begin
						nb_c = d_rdata;
						nu_c = v_c;
					end
				end
				best_d = nb_c;
				u_d    = nu_c;
				cnt_d  = cnt_q + SweepW'(1);
				if (cnt_q[CountW-1:0] == n_eff) begin
					cnt_d = '0;
					if (nu_c == n_eff) begin
						src_d   = src_q + CountW'(1);
						state_d = ST_SRC;
					end else begin
						done_d[nu_c[NodeW-1:0]] = 1'b1;
						state_d = ST_RELAX;
					end
				end
			end
			ST_RELAX: begin
				e_raddr = {u_q[NodeW-1:0], cnt_q[NodeW-1:0]};
				d_raddr = {src_q[NodeW-1:0], cnt_q[NodeW-1:0]};
				if (cnt_q != '0 && e_rdata != '0 && cand_c < {1'b0, d_rdata}) begin
					d_we    = 1'b1;
					d_waddr = {src_q[NodeW-1:0], v_c[NodeW-1:0]};
					d_wdata = cand_c[DistW-1:0];
				end
				cnt_d = cnt_q + SweepW'(1);
				if (cnt_q[CountW-1:0] == n_eff) begin
					cnt_d   = '0;
					best_d  = DistLimit;
					u_d     = n_eff;
					state_d = ST_SCAN;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!in_stall |-> state_q == ST_IDLE)
		else $error("input taken while busy");

	a_reach: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && reachable |-> distance < DistLimit && !status)
		else $error("reachable result with limit distance");

	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status |-> distance == '0 && !reachable)
		else $error("rejected item carries a distance");

	a_relax_row: assert property (@(posedge clk) disable iff (!arst_n)
		d_we && state_q == ST_RELAX |-> d_wdata < DistLimit)
		else $error("relaxation wrote an unreachable value");

endmodule
